// ===== src/delta_list_sleep_timer_queue_macros.svh =====
// assertion macros for the delta list sleep timer queue
// no dependencies; included by modules that carry assertions
`ifndef DELTA_LIST_SLEEP_TIMER_QUEUE_MACROS_SVH
`define DELTA_LIST_SLEEP_TIMER_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define DLSTQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("dlstq check failed");
`define DLSTQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("dlstq check failed");
`else
`define DLSTQ_ASSERT(lbl, clk, rstn, prop)
`define DLSTQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/dlstq_pkg.sv =====
// types and codes shared by the sleep timer queue modules
// no dependencies
package dlstq_pkg;
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] EV_INSERTED  = 2'd0;
    localparam logic [1:0] EV_REJECTED  = 2'd1;
    localparam logic [1:0] EV_WOKEN     = 2'd2;
    localparam logic [1:0] EV_CANCELLED = 2'd3;

    localparam logic [19:0] TICK_RESET = 20'd10000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  task_id;
        logic [30:0] sleep_time;
    } in_t;

    typedef struct packed {
        logic [1:0]         event_code;
        logic [7:0]         woken_task;
        logic signed [31:0] time_left;
        logic               last_result;
    } out_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  task_id;
        logic [30:0] sleep_time;
    } cmd_t;
endpackage

// ===== src/dlstq_front.sv =====
// front end: accepts requests, classifies them, holds them in a two-entry queue
// depends on dlstq_pkg
module dlstq_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dlstq_pkg::in_t  s_data,
    output logic            q_valid,
    output dlstq_pkg::cmd_t q_cmd,
    input  logic            q_pop
);
    import dlstq_pkg::*;

    cmd_t       mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cls;
    logic       push;

    always_comb begin
        cls.task_id    = s_data.task_id;
        cls.sleep_time = s_data.sleep_time;
        unique case (s_data.req_type)
            REQ_INSERT: cls.kind = KIND_INSERT;
            REQ_TICK:   cls.kind = KIND_TICK;
            REQ_CANCEL: cls.kind = KIND_CANCEL;
            default:    cls.kind = KIND_NONE;
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = (q_pop && q_valid) ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= cls;
        end
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end
endmodule

// ===== src/dlstq_back.sv =====
// back end: delta list storage, walk sequencer and result register
// depends on dlstq_pkg and the assertion macro header
`include "delta_list_sleep_timer_queue_macros.svh"
module dlstq_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [19:0]     tick_period,
    input  logic            q_valid,
    input  dlstq_pkg::cmd_t q_cmd,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output dlstq_pkg::out_t m_data
);
    import dlstq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INS  = 2'd1;
    localparam logic [1:0] ST_TICK = 2'd2;
    localparam logic [1:0] ST_CAN  = 2'd3;

    logic [7:0]    slot_task_reg  [QUEUE_DEPTH];
    logic [7:0]    slot_task_next [QUEUE_DEPTH];
    logic [30:0]   slot_delta_reg [QUEUE_DEPTH];
    logic [30:0]   slot_delta_next[QUEUE_DEPTH];
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    state_reg, state_next;
    cmd_t          cur_reg, cur_next;
    logic [30:0]   rest_reg, rest_next;
    logic [20:0]   passed_reg, passed_next;
    out_t          out_reg, out_next;
    logic          out_vld_reg, out_vld_next;

    logic               out_free;
    logic [IW-1:0]      ix;
    logic [30:0]        dsel;
    logic signed [31:0] ins_diff;
    logic signed [32:0] tick_d;
    logic signed [32:0] wake_next;
    logic signed [32:0] neg_d;
    logic               ins_done;

    assign out_free  = !out_vld_reg || m_ready;
    assign ix        = idx_reg[IW-1:0];
    assign dsel      = slot_delta_reg[ix];
    assign ins_diff  = $signed({1'b0, rest_reg}) - $signed({1'b0, dsel});
    assign tick_d    = $signed({2'b0, slot_delta_reg[0]}) - $signed({12'b0, passed_reg});
    assign wake_next = $signed({2'b0, slot_delta_reg[1]}) + tick_d;
    assign neg_d     = -tick_d;
    assign ins_done  = !((idx_reg < len_reg) && (ins_diff > 0));
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;

    always_comb begin
        slot_task_next  = slot_task_reg;
        slot_delta_next = slot_delta_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        state_next   = state_reg;
        cur_next     = cur_reg;
        rest_next    = rest_reg;
        passed_next  = passed_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !m_ready;
        q_pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    cur_next    = q_cmd;
                    rest_next   = q_cmd.sleep_time;
                    idx_next    = '0;
                    passed_next = {1'b0, tick_period};
                    unique case (q_cmd.kind)
                        KIND_INSERT: state_next = ST_INS;
                        KIND_TICK:   state_next = ST_TICK;
                        KIND_CANCEL: state_next = ST_CAN;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INS: begin
                if (len_reg == FULL) begin
                    if (out_free) begin
                        out_next     = '{EV_REJECTED, cur_reg.task_id,
                                         $signed({1'b0, cur_reg.sleep_time}), 1'b1};
                        out_vld_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else if (!ins_done) begin
                    rest_next = ins_diff[30:0];
                    idx_next  = idx_reg + 1'b1;
                end else if (out_free) begin
                    for (int j = 1; j < QUEUE_DEPTH; j++) begin
                        if (CW'(j) > idx_reg) begin
                            slot_task_next[j]  = slot_task_reg[j-1];
                            slot_delta_next[j] = slot_delta_reg[j-1];
                        end
                        if (CW'(j) == idx_reg + 1'b1 && CW'(j) <= len_reg) begin
                            slot_delta_next[j] = slot_delta_reg[j-1] - rest_reg;
                        end
                    end
                    slot_task_next[ix]  = cur_reg.task_id;
                    slot_delta_next[ix] = rest_reg;
                    len_next     = len_reg + 1'b1;
                    out_next     = '{EV_INSERTED, cur_reg.task_id,
                                     $signed({1'b0, rest_reg}), 1'b1};
                    out_vld_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (len_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (tick_d > 0) begin
                    slot_delta_next[0] = tick_d[30:0];
                    state_next         = ST_IDLE;
                end else if (out_free) begin
                    // head is due: report overshoot and pop it
                    out_next     = '{EV_WOKEN, slot_task_reg[0], tick_d[31:0],
                                     (len_reg == CW'(1)) || (wake_next > 0)};
                    out_vld_next = 1'b1;
                    for (int j = 1; j < QUEUE_DEPTH; j++) begin
                        slot_task_next[j-1]  = slot_task_reg[j];
                        slot_delta_next[j-1] = slot_delta_reg[j];
                    end
                    len_next    = len_reg - 1'b1;
                    passed_next = neg_d[20:0];
                end
            end
            ST_CAN: begin
                if (idx_reg >= len_reg) begin
                    state_next = ST_IDLE;
                end else if (slot_task_reg[ix] == cur_reg.task_id) begin
                    if (out_free) begin
                        for (int j = 1; j < QUEUE_DEPTH; j++) begin
                            if (CW'(j) > idx_reg) begin
                                slot_task_next[j-1]  = slot_task_reg[j];
                                slot_delta_next[j-1] = slot_delta_reg[j];
                            end
                            if (CW'(j) == idx_reg + 1'b1) begin
                                slot_delta_next[j-1] = slot_delta_reg[j] + dsel;
                            end
                        end
                        len_next     = len_reg - 1'b1;
                        out_next     = '{EV_CANCELLED, cur_reg.task_id,
                                         $signed({1'b0, dsel}), 1'b1};
                        out_vld_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        slot_task_reg  <= slot_task_next;
        slot_delta_reg <= slot_delta_next;
        cur_reg    <= cur_next;
        rest_reg   <= rest_next;
        passed_reg <= passed_next;
        idx_reg    <= idx_next;
        out_reg    <= out_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            out_vld_reg <= out_vld_next;
        end
    end

    `DLSTQ_ASSERT(a_len_bound, aclk, aresetn, len_reg <= FULL)
    `DLSTQ_ASSERT(a_ins_grows, aclk, aresetn,
        (state_reg == ST_INS && len_reg != FULL && ins_done && out_free)
        |=> len_reg == $past(len_reg) + 1'b1)
    `DLSTQ_ASSERT(a_tick_empty, aclk, aresetn,
        (state_reg == ST_TICK && len_reg == '0) |=> state_reg == ST_IDLE)
endmodule

// ===== src/delta_list_sleep_timer_queue.sv =====
// top level of the delta list sleep timer queue
// depends on dlstq_pkg, dlstq_front and dlstq_back
// the queue keeps up to QUEUE_DEPTH sleeping tasks as a delta list, each entry
// holding its time beyond the entry before it. requests come in over s_ and
// land in a two-entry queue, so a new transfer is taken while the back end
// works. an insert walks the list one entry per cycle; a cancel walks until
// the task is found; a tick wakes each due task in turn. the walk over the
// entry registers sets the rate. each result is a transfer on m_ with
// last_result on the final one of a request; a tick with nothing due and a
// cancel of an absent task give none. the user writes tick_period through
// cfg_wr_en / cfg_wr_data only while idle; the block does not enforce this.
module delta_list_sleep_timer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [19:0]     cfg_wr_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  dlstq_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dlstq_pkg::out_t m_data
);
    import dlstq_pkg::*;

    logic [19:0] tick_period_reg;
    logic        q_valid;
    cmd_t        q_cmd;
    logic        q_pop;

    // tick period register, reset to the default period
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg <= TICK_RESET;
        end else if (cfg_wr_en) begin
            tick_period_reg <= cfg_wr_data;
        end
    end

    // front end: accept and classify
    dlstq_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    // back end: list walk and result register
    dlstq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_period (tick_period_reg),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );
endmodule

// ===== sim/tb_delta_list_sleep_timer_queue.sv =====
// testbench for the delta list sleep timer queue: directed and random requests
// depends on dlstq_pkg and delta_list_sleep_timer_queue; predicts every result and compares
module tb_delta_list_sleep_timer_queue;
    import dlstq_pkg::*;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [19:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    delta_list_sleep_timer_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // predictor state: our own copy of the delta list
    logic [7:0] sleeper_task [DEPTH];
    logic [30:0] sleeper_delta [DEPTH];
    int sleeper_count;
    logic [19:0] tick_us;

    out_t pending_events[$];
    int errors;
    bit send_idle_en;     // sender inserts random gaps
    bit recv_idle_en;     // receiver inserts random gaps
    int recv_hold;        // cycles the receiver must still hold off
    int quiet_cycles;

    function automatic out_t make_event(logic [1:0] code, logic [7:0] tid,
                                        logic signed [31:0] left);
        out_t e;
        e.event_code = code;
        e.woken_task = tid;
        e.time_left = left;
        e.last_result = 1'b0;
        return e;
    endfunction

    // work out the results of one request and update the predicted list
    function automatic void predict_request(in_t r);
        longint rest, d, passed;
        int i, j, n;
        out_t e;
        n = 0;
        case (r.req_type)
            REQ_INSERT: begin
                if (sleeper_count >= DEPTH) begin
                    pending_events.push_back(make_event(EV_REJECTED, r.task_id,
                                                        {1'b0, r.sleep_time}));
                    n = 1;
                end else begin
                    rest = r.sleep_time;
                    for (i = 0; i < sleeper_count; i++) begin
                        if (rest - longint'(sleeper_delta[i]) <= 0) break;
                        rest -= longint'(sleeper_delta[i]);
                    end
                    for (j = sleeper_count; j > i; j--) begin
                        sleeper_task[j] = sleeper_task[j-1];
                        sleeper_delta[j] = sleeper_delta[j-1];
                    end
                    sleeper_task[i] = r.task_id;
                    sleeper_delta[i] = rest[30:0];
                    sleeper_count++;
                    if (i + 1 < sleeper_count)
                        sleeper_delta[i+1] = sleeper_delta[i+1] - rest[30:0];
                    pending_events.push_back(make_event(EV_INSERTED, r.task_id,
                                                        rest[31:0]));
                    n = 1;
                end
            end
            REQ_TICK: begin
                passed = tick_us;
                while (sleeper_count > 0) begin
                    d = longint'(sleeper_delta[0]) - passed;
                    if (d > 0) begin
                        sleeper_delta[0] = d[30:0];
                        break;
                    end
                    // woken with its overshoot, which carries to the next head
                    pending_events.push_back(make_event(EV_WOKEN, sleeper_task[0], d[31:0]));
                    n++;
                    passed = -d;
                    for (j = 1; j < sleeper_count; j++) begin
                        sleeper_task[j-1] = sleeper_task[j];
                        sleeper_delta[j-1] = sleeper_delta[j];
                    end
                    sleeper_count--;
                end
            end
            REQ_CANCEL: begin
                for (i = 0; i < sleeper_count; i++)
                    if (sleeper_task[i] == r.task_id) break;
                if (i < sleeper_count) begin
                    d = sleeper_delta[i];
                    for (j = i + 1; j < sleeper_count; j++) begin
                        sleeper_task[j-1] = sleeper_task[j];
                        sleeper_delta[j-1] = sleeper_delta[j];
                    end
                    sleeper_count--;
                    if (i < sleeper_count)
                        sleeper_delta[i] = sleeper_delta[i] + d[30:0];
                    pending_events.push_back(make_event(EV_CANCELLED, r.task_id, d[31:0]));
                    n = 1;
                end
            end
            default: ;  // unused code, ignored
        endcase
        if (n > 0) begin
            e = pending_events.pop_back();
            e.last_result = 1'b1;
            pending_events.push_back(e);
        end
    endfunction

    // one transfer on s_, with an optional random gap first
    // returns at the accepting edge; the next falling edge drives s_ again
    task automatic send_request(logic [1:0] kind, logic [7:0] tid, logic [30:0] sleep);
        in_t r;
        r.req_type = kind;
        r.task_id = tid;
        r.sleep_time = sleep;
        @(negedge aclk);
        while (send_idle_en && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(r);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_tick(logic [19:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        tick_us = val;
    endtask

    function automatic logic [30:0] rand_sleep();
        case ($urandom_range(5))
            0: return 31'h7fffffff;
            1: return 31'd0;
            2: return 31'($urandom);
            default: return 31'($urandom_range(60000));
        endcase
    endfunction

    // extremes, every request kind and the special cases
    task automatic test_directed();
        send_request(REQ_TICK, 8'd0, 31'd0);              // tick on empty queue
        send_request(REQ_CANCEL, 8'd9, 31'd0);            // cancel of absent task
        send_request(REQ_INSERT, 8'hff, 31'd25000);
        send_request(REQ_INSERT, 8'h00, 31'd25000);       // equal cumulative time
        send_request(REQ_INSERT, 8'h55, 31'h7fffffff);
        send_request(REQ_INSERT, 8'haa, 31'd0);
        send_request(REQ_INSERT, 8'hff, 31'd5000);        // duplicate id
        send_request(REQ_CANCEL, 8'hff, 31'h7fffffff);
        send_request(2'd3, 8'h12, 31'd77);                // unused code
        send_request(REQ_TICK, 8'hff, 31'h7fffffff);
        send_request(REQ_TICK, 8'd0, 31'd0);
        send_request(REQ_TICK, 8'd0, 31'd0);
        write_tick(20'd0);                                // zero period wakes zero deltas
        send_request(REQ_INSERT, 8'd3, 31'd0);
        send_request(REQ_TICK, 8'd0, 31'd0);
        write_tick(20'hfffff);
        for (int k = 0; k < 18; k++)                      // fill up, then rejects
            send_request(REQ_INSERT, 8'(k), 31'($urandom_range(3000000)));
    endtask

    // receiver holds off while the sender keeps offering, so the block stalls
    task automatic test_backpressure();
        recv_hold = 400;
        for (int k = 0; k < 20; k++)
            send_request($urandom_range(1) ? REQ_TICK : REQ_CANCEL, 8'($urandom_range(17)),
                         rand_sleep());
        // sender pauses until every expected result has come
        wait_drained();
    endtask

    task automatic test_random(int count, bit idle);
        logic [1:0] kind;
        int roll;
        send_idle_en = idle;
        recv_idle_en = idle;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 45) kind = REQ_INSERT;
            else if (roll < 70) kind = REQ_TICK;
            else if (roll < 97) kind = REQ_CANCEL;
            else kind = 2'd3;
            send_request(kind, $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(23)),
                         rand_sleep());
        end
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    // result checker: compare each m_ transfer with the oldest expectation
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected result %p", m_data);
                errors++;
            end else begin
                want = pending_events.pop_front();
                if (m_data.event_code !== want.event_code) begin
                    $error("event_code expected %0d got %0d", want.event_code,
                           m_data.event_code);
                    errors++;
                end
                if (m_data.woken_task !== want.woken_task) begin
                    $error("woken_task expected %0d got %0d", want.woken_task,
                           m_data.woken_task);
                    errors++;
                end
                if (m_data.time_left !== want.time_left) begin
                    $error("time_left expected %0d got %0d", want.time_left,
                           m_data.time_left);
                    errors++;
                end
                if (m_data.last_result !== want.last_result) begin
                    $error("last_result expected %0d got %0d", want.last_result,
                           m_data.last_result);
                    errors++;
                end
            end
        end
    end

    // receiver ready, with random idling and the long hold-off
    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(recv_idle_en && $urandom_range(99) < 31);
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || recv_hold > 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("delta_list_sleep_timer_queue regression: fail");
            $finish;
        end
    end

    initial begin
        errors = 0;
        sleeper_count = 0;
        tick_us = TICK_RESET;
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
        recv_hold = 0;
        quiet_cycles = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_backpressure();
        write_tick(20'd1);
        test_random(80, 1'b1);
        write_tick(20'd10000);
        test_random(150, 1'b0);
        write_tick(20'($urandom_range(1, 40000)));
        test_random(250, 1'b1);
        wait_drained();
        if (errors == 0)
            $display("delta_list_sleep_timer_queue regression: pass");
        else
            $display("delta_list_sleep_timer_queue regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/dlstq_pkg.sv
src/dlstq_front.sv
src/dlstq_back.sv
src/delta_list_sleep_timer_queue.sv
sim/tb_delta_list_sleep_timer_queue.sv
